[rtl/core/multiply_accumulate_early_term_assert.svh]
// Assertion macros for the multiply-accumulate block.
// Compiled out when SYNTHESIS is defined; no other dependencies.
`ifndef MULTIPLY_ACCUMULATE_EARLY_TERM_ASSERT_SVH
`define MULTIPLY_ACCUMULATE_EARLY_TERM_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define MACET_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("macet assertion failed");

// Check that a condition never holds outside reset.
`define MACET_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("macet forbidden condition seen");

`else

`define MACET_ASSERT(label, clk, rst_n, prop)
`define MACET_NEVER(label, clk, rst_n, cond)

`endif

`endif

[rtl/core/macet_pkg.sv]
// Shared types, action codes and helper functions for the multiply-accumulate block.
// No dependencies.
`timescale 1ns / 1ps

package macet_pkg;

    localparam int WORD_W   = 32;
    localparam int DWORD_W  = 2 * WORD_W;
    localparam int ACTION_W = 3;
    localparam int CYCLES_W = 3;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_MUL   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_MLA   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_UMULL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UMLAL = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SMULL = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_SMLAL = 3'd5;

    // Early termination masks on the multiplier's upper bytes
    localparam logic [WORD_W-1:0] TERM_MASK_1 = 32'hFFFF_FF00;
    localparam logic [WORD_W-1:0] TERM_MASK_2 = 32'hFFFF_0000;
    localparam logic [WORD_W-1:0] TERM_MASK_3 = 32'hFF00_0000;

    localparam logic [CYCLES_W-1:0] CYCLES_MIN = 3'd1;
    localparam logic [CYCLES_W-1:0] CYCLES_MAX = 3'd6;

    typedef struct packed {
        logic is_long;
        logic is_signed;
        logic accumulate;
        logic set_flags;
    } t_mul_ctl;

    function automatic t_mul_ctl decode_action(input logic [ACTION_W-1:0] action,
                                               input logic set_flags);
        t_mul_ctl ctl;
        ctl.is_long    = (action != ACT_MUL) && (action != ACT_MLA);
        ctl.is_signed  = (action >= ACT_SMULL);
        // low bit selects accumulate; unused codes fold onto the signed long forms
        ctl.accumulate = action[0];
        ctl.set_flags  = set_flags;
        return ctl;
    endfunction

    function automatic logic upper_done(input logic [WORD_W-1:0] m,
                                        input logic [WORD_W-1:0] mask,
                                        input logic allow_ones);
        return ((m & mask) == '0) || (allow_ones && ((~m & mask) == '0));
    endfunction

    function automatic logic [CYCLES_W-1:0] term_stage(input logic [WORD_W-1:0] m,
                                                       input logic allow_ones);
        logic [CYCLES_W-1:0] stage;
        if (upper_done(m, TERM_MASK_1, allow_ones)) begin
            stage = 3'd1;
        end else if (upper_done(m, TERM_MASK_2, allow_ones)) begin
            stage = 3'd2;
        end else if (upper_done(m, TERM_MASK_3, allow_ones)) begin
            stage = 3'd3;
        end else begin
            stage = 3'd4;
        end
        return stage;
    endfunction

endpackage

[rtl/core/macet_ifs.sv]
// Request and response channel interfaces for the multiply-accumulate block.
// Depends on macet_pkg for field widths.
`timescale 1ns / 1ps

interface macet_req_if import macet_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   multiplicand;
    logic [WORD_W-1:0]   multiplier;
    logic [WORD_W-1:0]   addend_low;
    logic [WORD_W-1:0]   addend_high;
    logic                set_flags;

    modport source (output valid, action, multiplicand, multiplier, addend_low,
                    addend_high, set_flags, input ready);
    modport sink   (input valid, action, multiplicand, multiplier, addend_low,
                    addend_high, set_flags, output ready);
endinterface

interface macet_rsp_if import macet_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   product_low;
    logic [WORD_W-1:0]   product_high;
    logic                flags_written;
    logic                zero_flag;
    logic                negative_flag;
    logic [CYCLES_W-1:0] extra_cycles;

    modport source (output valid, product_low, product_high, flags_written, zero_flag,
                    negative_flag, extra_cycles, input ready);
    modport sink   (input valid, product_low, product_high, flags_written, zero_flag,
                    negative_flag, extra_cycles, output ready);
endinterface

[rtl/core/macet_mul.sv]
// Multiply core: 33x33 signed product and early-termination cycle count.
// Depends on macet_pkg.
`timescale 1ns / 1ps

module macet_mul import macet_pkg::*; (
    input  logic [WORD_W-1:0]   i_multiplicand,
    input  logic [WORD_W-1:0]   i_multiplier,
    input  t_mul_ctl            i_ctl,
    output logic [DWORD_W-1:0]  o_product,
    output logic [CYCLES_W-1:0] o_cycles
);

    logic signed [WORD_W:0]      w_a;
    logic signed [WORD_W:0]      w_b;
    logic signed [2*WORD_W+1:0]  w_full;
    logic [CYCLES_W-1:0]         w_stage;

    // Extend by one bit: sign for signed long, zero otherwise
    assign w_a    = $signed({i_ctl.is_signed & i_multiplicand[WORD_W-1], i_multiplicand});
    assign w_b    = $signed({i_ctl.is_signed & i_multiplier[WORD_W-1], i_multiplier});
    assign w_full = w_a * w_b;
    assign o_product = w_full[DWORD_W-1:0];

    // Unsigned long forms terminate only on all-zero upper bytes
    assign w_stage  = term_stage(i_multiplier, !i_ctl.is_long || i_ctl.is_signed);
    assign o_cycles = w_stage + {{(CYCLES_W-1){1'b0}}, i_ctl.accumulate}
                              + {{(CYCLES_W-1){1'b0}}, i_ctl.is_long};

endmodule

[rtl/core/multiply_accumulate_early_term.sv]
// Top level of the multiply-accumulate block with early-termination cycle count.
// Depends on macet_pkg, macet_ifs, macet_mul and the assertion macro header.
`timescale 1ns / 1ps

// Multiply unit for 32-bit MUL/MLA and 64-bit unsigned or signed long multiply with
// optional 64-bit accumulate. Takes one item per clock while not stalled and returns one
// result item per item, in order. An accepted item passes through three registers: an
// input register, a product register behind the single 33x33 signed multiplier, and an
// output register behind the 64-bit accumulate add and the zero and negative flags.
// Throughput is one item per cycle while the output is not blocked; each stage stalls
// only when the one after it is full and blocked, so bubbles close up and the block
// takes up to two more items while a finished result waits at the output.
// extra_cycles reports the cycle count an iterative multiplier would spend (termination
// stage, plus one for accumulate, plus one for long); it is computed, not spent. Short
// forms return zero in product_high; flags read zero when set_flags is low.

`include "multiply_accumulate_early_term_assert.svh"

module multiply_accumulate_early_term import macet_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    macet_req_if.sink   i_req,
    macet_rsp_if.source o_rsp
);

    // Stage 0: accepted item
    logic                r_s0_valid;
    logic [WORD_W-1:0]   r_s0_multiplicand;
    logic [WORD_W-1:0]   r_s0_multiplier;
    logic [DWORD_W-1:0]  r_s0_addend;
    t_mul_ctl            r_s0_ctl;

    // Stage 1: product and cycle count
    logic                r_s1_valid;
    logic [DWORD_W-1:0]  r_s1_product;
    logic [DWORD_W-1:0]  r_s1_addend;
    logic [CYCLES_W-1:0] r_s1_cycles;
    t_mul_ctl            r_s1_ctl;

    // Stage 2: output register
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_low;
    logic [WORD_W-1:0]   r_out_high;
    logic                r_out_flags;
    logic                r_out_zero;
    logic                r_out_neg;
    logic [CYCLES_W-1:0] r_out_cycles;

    logic                w_rdy0;
    logic                w_rdy1;
    logic                w_rdy2;
    logic                w_s1_move;
    logic [DWORD_W-1:0]  w_product;
    logic [CYCLES_W-1:0] w_cycles;
    logic [DWORD_W-1:0]  w_add;
    logic [DWORD_W-1:0]  w_sum;
    logic                w_zero;
    logic                w_neg;

    // A stage loads when it is empty or its contents move on this cycle
    assign w_rdy2 = !r_out_valid || o_rsp.ready;
    assign w_rdy1 = !r_s1_valid || w_rdy2;
    assign w_rdy0 = !r_s0_valid || w_rdy1;
    assign i_req.ready = w_rdy0;

    // Stage 1 hands its item to the output register
    assign w_s1_move = r_s1_valid && w_rdy2;

    macet_mul u_mul (
        .i_multiplicand (r_s0_multiplicand),
        .i_multiplier   (r_s0_multiplier),
        .i_ctl          (r_s0_ctl),
        .o_product      (w_product),
        .o_cycles       (w_cycles)
    );

    // Accumulate operand: full 64 bits for long forms, low word only for short forms
    always_comb begin
        w_add = '0;
        if (r_s1_ctl.accumulate) begin
            w_add = r_s1_ctl.is_long ? r_s1_addend : {{WORD_W{1'b0}}, r_s1_addend[WORD_W-1:0]};
        end
        w_sum = r_s1_product + w_add;
        if (r_s1_ctl.is_long) begin
            w_zero = (w_sum == '0);
            w_neg  = w_sum[DWORD_W-1];
        end else begin
            w_zero = (w_sum[WORD_W-1:0] == '0);
            w_neg  = w_sum[WORD_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_s0_valid <= i_req.valid;
            end
            if (w_rdy1) begin
                r_s1_valid <= r_s0_valid;
            end
            if (w_rdy2) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload: capture on load, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_req.valid) begin
            r_s0_multiplicand <= i_req.multiplicand;
            r_s0_multiplier   <= i_req.multiplier;
            r_s0_addend       <= {i_req.addend_high, i_req.addend_low};
            r_s0_ctl          <= decode_action(i_req.action, i_req.set_flags);
        end
        if (w_rdy1 && r_s0_valid) begin
            r_s1_product <= w_product;
            r_s1_addend  <= r_s0_addend;
            r_s1_cycles  <= w_cycles;
            r_s1_ctl     <= r_s0_ctl;
        end
        if (w_s1_move) begin
            r_out_low    <= w_sum[WORD_W-1:0];
            r_out_high   <= r_s1_ctl.is_long ? w_sum[DWORD_W-1:WORD_W] : '0;
            r_out_flags  <= r_s1_ctl.set_flags;
            r_out_zero   <= r_s1_ctl.set_flags & w_zero;
            r_out_neg    <= r_s1_ctl.set_flags & w_neg;
            r_out_cycles <= r_s1_cycles;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.product_low   = r_out_low;
    assign o_rsp.product_high  = r_out_high;
    assign o_rsp.flags_written = r_out_flags;
    assign o_rsp.zero_flag     = r_out_zero;
    assign o_rsp.negative_flag = r_out_neg;
    assign o_rsp.extra_cycles  = r_out_cycles;

    `MACET_ASSERT(a_cycles_min, i_clk, i_rst_n, r_out_valid |-> r_out_cycles >= CYCLES_MIN)
    `MACET_ASSERT(a_cycles_max, i_clk, i_rst_n, r_out_valid |-> r_out_cycles <= CYCLES_MAX)
    `MACET_NEVER(a_no_flags, i_clk, i_rst_n, r_out_valid && !r_out_flags && (r_out_zero | r_out_neg))
    `MACET_ASSERT(a_short_high, i_clk, i_rst_n, w_s1_move && !r_s1_ctl.is_long |=> r_out_high == '0)
    `MACET_ASSERT(a_s1_to_out, i_clk, i_rst_n, w_s1_move |=> r_out_valid)
    `MACET_ASSERT(a_accept_loads, i_clk, i_rst_n, (i_req.valid && w_rdy0) |=> r_s0_valid)

endmodule
